FILE: rtl/sam_pkg.sv
package sam_pkg;

  // Time arithmetic width; stamps and differences wrap at this width.
  localparam int TIME_BITS = 32;
  typedef logic [TIME_BITS-1:0] time_t;

  localparam int NumChan = 6;
  localparam int ChanIdxW = $clog2(NumChan);
  typedef logic [ChanIdxW-1:0] chan_idx_t;

  // Time store: one entry per alarm channel plus the buzzer stamp.
  localparam int TimeEntries = NumChan + 1;
  localparam int TimeIdxW = $clog2(TimeEntries);
  typedef logic [TimeIdxW-1:0] time_idx_t;
  localparam time_idx_t BeepEntry = time_idx_t'(NumChan);

  localparam int TempHyst  = 2;
  localparam int SoilHyst  = 5;
  localparam int LightHyst = 200;
  localparam int SunHyst   = 10000;
  localparam int BeepMs    = 1000;

  typedef logic [3:0] src_t;
  localparam src_t SrcRelay  = 4'd6;
  localparam src_t SrcMode   = 4'd7;
  localparam src_t SrcStatus = 4'd8;

  typedef logic [1:0] kind_t;
  localparam kind_t KindRaised   = 2'd0;
  localparam kind_t KindRepeated = 2'd1;
  localparam kind_t KindCleared  = 2'd2;

  typedef enum logic [2:0] {
    CfgTempHigh,
    CfgSoilLow,
    CfgLightLow,
    CfgPhMin,
    CfgPhMax,
    CfgSunLimit,
    CfgRepeat,
    CfgBuzzer
  } cfg_idx_e;

  // One slot per cycle unless the output stalls on an emitting slot: change item, six channels, status item.
  typedef logic [2:0] slot_t;
  localparam slot_t SlotChange = 3'd0;
  localparam slot_t SlotStatus = 3'd7;

  typedef struct packed {
    logic [NumChan-1:0] raise;
    logic [NumChan-1:0] clear;
  } chan_flags_t;

endpackage

FILE: rtl/sam_thresh.sv
module sam_thresh (
  input  logic [7:0]          temperature_i,
  input  logic [6:0]          soil_moisture_i,
  input  logic [16:0]         light_level_i,
  input  logic [7:0]          ph_tenths_i,
  input  logic                rain_seen_i,
  input  logic [7:0]          temp_high_i,
  input  logic [6:0]          soil_low_i,
  input  logic [16:0]         light_low_i,
  input  logic [7:0]          ph_min_i,
  input  logic [7:0]          ph_max_i,
  input  logic [16:0]         sun_limit_i,
  output sam_pkg::chan_flags_t flags_o
);
  import sam_pkg::*;

  logic signed [8:0] temp_x;
  logic signed [8:0] tlim_x;
  logic signed [8:0] temp_clr;
  logic [7:0]        soil_clr;
  logic [17:0]       light_clr;
  logic [17:0]       sun_off;

  assign temp_x    = {temperature_i[7], temperature_i};
  assign tlim_x    = {temp_high_i[7], temp_high_i};
  assign temp_clr  = tlim_x - $signed(9'(TempHyst));
  assign soil_clr  = {1'b0, soil_low_i} + 8'(SoilHyst);
  assign light_clr = {1'b0, light_low_i} + 18'(LightHyst);
  // sun clears below limit minus hysteresis; compare with the offset on the reading side
  assign sun_off   = {1'b0, light_level_i} + 18'(SunHyst);

  always_comb begin
    flags_o.raise[0] = temp_x >= tlim_x;
    flags_o.clear[0] = temp_x <= temp_clr;
    flags_o.raise[1] = soil_moisture_i <= soil_low_i;
    flags_o.clear[1] = {1'b0, soil_moisture_i} >= soil_clr;
    flags_o.raise[2] = light_level_i < light_low_i;
    flags_o.clear[2] = {1'b0, light_level_i} >= light_clr;
    flags_o.raise[3] = (ph_tenths_i < ph_min_i) || (ph_tenths_i > ph_max_i);
    flags_o.clear[3] = 1'b1;
    flags_o.raise[4] = rain_seen_i;
    flags_o.clear[4] = 1'b1;
    flags_o.raise[5] = light_level_i >= sun_limit_i;
    flags_o.clear[5] = sun_off < {1'b0, sun_limit_i};
  end

endmodule

FILE: rtl/sam_time_store.sv
module sam_time_store (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sam_pkg::time_idx_t rd_idx_i,
  input  logic               wr_en_i,
  input  sam_pkg::time_idx_t wr_idx_i,
  input  sam_pkg::time_t     wr_data_i,
  output sam_pkg::time_t     rd_data_o
);
  import sam_pkg::*;

  time_t                  mem_q [TimeEntries];
  logic [TimeEntries-1:0] valid_q;
  time_t                  rd_data_q;
  logic                   rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_idx_i];
  end

  // Entries never written read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_idx_i];
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

FILE: rtl/sensor_alarm_monitor.sv
// A request is taken into the input register and loaded into the slot sequencer; the result
// of each slot (change 0, status 7) is registered. One slot a cycle, unless the output stalls,
// through the single-read time store; a further request waits in the input register.
// Output stall pauses the slot sequencer only on slots that emit a result.
// Reset: control and config registers to their defaults, alarms cleared, stamps cleared at once by the
// time store's valid bits; no clearing pass.
module sensor_alarm_monitor (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic signed [7:0] temperature_i,
  input  logic [6:0]        soil_moisture_i,
  input  logic [16:0]       light_level_i,
  input  logic [7:0]        ph_tenths_i,
  input  logic              rain_seen_i,
  input  logic              auto_mode_i,
  input  logic [3:0]        relay_bits_i,
  input  logic [31:0]       now_ms_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [3:0]        alarm_source_o,
  output logic [1:0]        alarm_kind_o,
  output logic signed [17:0] reading_o,
  output logic              mode_before_o,
  output logic              mode_now_o,
  output logic [3:0]        relays_before_o,
  output logic [3:0]        relays_now_o,
  output logic [5:0]        alarm_mask_o,
  output logic              beep_o,
  output logic              final_item_o
);
  import sam_pkg::*;

  // configuration
  logic [7:0]  temp_high_q;
  logic [6:0]  soil_low_q;
  logic [16:0] light_low_q;
  logic [7:0]  ph_min_q;
  logic [7:0]  ph_max_q;
  logic [16:0] sun_limit_q;
  logic [31:0] repeat_q;
  logic        buzzer_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_high_q <= 8'd35;
      soil_low_q  <= 7'd30;
      light_low_q <= 17'd100;
      ph_min_q    <= 8'd40;
      ph_max_q    <= 8'd70;
      sun_limit_q <= 17'd20000;
      repeat_q    <= 32'd300000;
      buzzer_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgTempHigh: temp_high_q <= cfg_wdata_i[7:0];
        CfgSoilLow:  soil_low_q  <= cfg_wdata_i[6:0];
        CfgLightLow: light_low_q <= cfg_wdata_i[16:0];
        CfgPhMin:    ph_min_q    <= cfg_wdata_i[7:0];
        CfgPhMax:    ph_max_q    <= cfg_wdata_i[7:0];
        CfgSunLimit: sun_limit_q <= cfg_wdata_i[16:0];
        CfgRepeat:   repeat_q    <= cfg_wdata_i;
        CfgBuzzer:   buzzer_en_q <= cfg_wdata_i[0];
      endcase
    end
  end

  // input register
  logic        buf_valid_q;
  logic [7:0]  buf_temp_q;
  logic [6:0]  buf_soil_q;
  logic [16:0] buf_light_q;
  logic [7:0]  buf_ph_q;
  logic        buf_rain_q;
  logic        buf_mode_q;
  logic [3:0]  buf_relays_q;
  time_t       buf_now_q;
  logic        in_acc;

  assign in_stall_o = buf_valid_q;
  assign in_acc     = in_valid_i && !buf_valid_q;

  // poll-level state
  logic [NumChan-1:0] alarm_active_q;
  logic               seen_first_q;
  logic               rem_mode_q;
  logic [3:0]         rem_relays_q;

  // slot sequencer
  logic               e_valid_q;
  slot_t              e_slot_q, e_slot_d;
  chan_flags_t        e_flags_q;
  logic [NumChan-1:0] e_mask_old_q;
  logic [NumChan-1:0] e_mask_new_q;
  logic               e_chg_q;
  src_t               e_chg_src_q;
  logic               e_mb_q, e_mode_q;
  logic [3:0]         e_rb_q, e_relays_q;
  logic [7:0]         e_temp_q;
  logic [6:0]         e_soil_q;
  logic [16:0]        e_light_q;
  logic [7:0]         e_ph_q;
  logic               e_rain_q;
  time_t              e_now_q;

  chan_flags_t        flags;
  logic [NumChan-1:0] mask_new;
  logic               load;
  logic               e_go;
  logic               out_free;

  sam_thresh u_thresh (
    .temperature_i   (buf_temp_q),
    .soil_moisture_i (buf_soil_q),
    .light_level_i   (buf_light_q),
    .ph_tenths_i     (buf_ph_q),
    .rain_seen_i     (buf_rain_q),
    .temp_high_i     (temp_high_q),
    .soil_low_i      (soil_low_q),
    .light_low_i     (light_low_q),
    .ph_min_i        (ph_min_q),
    .ph_max_i        (ph_max_q),
    .sun_limit_i     (sun_limit_q),
    .flags_o         (flags)
  );

  assign mask_new = flags.raise | (alarm_active_q & ~flags.clear);
  assign load     = buf_valid_q && (!e_valid_q || (e_go && e_slot_q == SlotStatus));

  // time store: read the entry of the slot being entered, write back on advance.
  // A channel entry is written at most once per poll and read again only in the next poll,
  // so read and write never meet on one entry.
  time_idx_t rd_idx;
  time_t     rd_time;
  logic      slot_wr;
  logic      wr_en;
  time_idx_t wr_idx;
  time_t     wr_data;

  always_comb begin
    e_slot_d = e_slot_q;
    if (load) begin
      e_slot_d = SlotChange;
    end else if (e_go) begin
      e_slot_d = e_slot_q + slot_t'(1);
    end
    if (e_slot_d == SlotStatus) begin
      rd_idx = BeepEntry;
    end else if (e_slot_d == SlotChange) begin
      rd_idx = '0;
    end else begin
      rd_idx = time_idx_t'(e_slot_d - slot_t'(1));
    end
  end

  sam_time_store u_time_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (rd_idx),
    .wr_en_i   (wr_en),
    .wr_idx_i  (wr_idx),
    .wr_data_i (wr_data),
    .rd_data_o (rd_time)
  );

  // slot evaluation
  chan_idx_t         ch;
  logic              act, rs, cl, due, beep_hit;
  time_t             elapsed;
  logic              emit;
  src_t              src;
  kind_t             kind;
  logic signed [17:0] reading;
  logic              fin;
  logic              beep;

  assign ch       = chan_idx_t'(e_slot_q - slot_t'(1));
  assign act      = e_mask_old_q[ch];
  assign rs       = e_flags_q.raise[ch];
  assign cl       = e_flags_q.clear[ch];
  assign elapsed  = e_now_q - rd_time;
  assign due      = elapsed >= time_t'(repeat_q);
  assign beep_hit = buzzer_en_q && (|e_mask_new_q[3:0]) && (elapsed >= time_t'(BeepMs));

  always_comb begin
    emit    = 1'b0;
    src     = src_t'(ch);
    kind    = KindRaised;
    reading = '0;
    fin     = 1'b0;
    beep    = 1'b0;
    slot_wr = 1'b0;
    wr_idx  = time_idx_t'(ch);
    wr_data = e_now_q;
    case (e_slot_q)
      SlotChange: begin
        emit = e_chg_q;
        src  = e_chg_src_q;
      end
      SlotStatus: begin
        emit    = 1'b1;
        src     = SrcStatus;
        fin     = 1'b1;
        beep    = beep_hit;
        slot_wr = beep_hit;
        wr_idx  = BeepEntry;
      end
      default: begin
        if (rs) begin
          emit    = !act || due;
          kind    = act ? KindRepeated : KindRaised;
          slot_wr = !act || due;
        end else if (act && cl) begin
          emit    = 1'b1;
          kind    = KindCleared;
          slot_wr = 1'b1;
          wr_data = '0;
        end
        case (ch)
          3'd0:    reading = 18'(e_temp_q) | {{10{e_temp_q[7]}}, 8'd0};
          3'd1:    reading = 18'(e_soil_q);
          3'd2:    reading = 18'(e_light_q);
          3'd3:    reading = 18'(e_ph_q);
          3'd4:    reading = 18'(e_rain_q);
          3'd5:    reading = 18'(e_light_q);
          default: reading = '0;
        endcase
      end
    endcase
  end

  assign out_free = !out_valid_o || !out_stall_i;
  assign e_go     = e_valid_q && (!emit || out_free);
  assign wr_en    = e_go && slot_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q    <= 1'b0;
      e_valid_q      <= 1'b0;
      e_slot_q       <= SlotChange;
      alarm_active_q <= '0;
      seen_first_q   <= 1'b0;
      rem_mode_q     <= 1'b0;
      rem_relays_q   <= '0;
      out_valid_o    <= 1'b0;
    end else begin
      if (in_acc) begin
        buf_valid_q <= 1'b1;
      end else if (load) begin
        buf_valid_q <= 1'b0;
      end
      e_slot_q <= e_slot_d;
      if (load) begin
        e_valid_q      <= 1'b1;
        alarm_active_q <= mask_new;
        seen_first_q   <= 1'b1;
        rem_mode_q     <= buf_mode_q;
        rem_relays_q   <= buf_relays_q;
      end else if (e_go && e_slot_q == SlotStatus) begin
        e_valid_q <= 1'b0;
      end
      if (e_valid_q && emit && out_free) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      buf_temp_q   <= temperature_i;
      buf_soil_q   <= soil_moisture_i;
      buf_light_q  <= light_level_i;
      buf_ph_q     <= ph_tenths_i;
      buf_rain_q   <= rain_seen_i;
      buf_mode_q   <= auto_mode_i;
      buf_relays_q <= relay_bits_i;
      buf_now_q    <= time_t'(now_ms_i);
    end
    if (load) begin
      e_flags_q    <= flags;
      e_mask_old_q <= alarm_active_q;
      e_mask_new_q <= mask_new;
      // mode change wins over relay change
      e_chg_q      <= seen_first_q &&
                      ((buf_mode_q != rem_mode_q) || (buf_relays_q != rem_relays_q));
      e_chg_src_q  <= (buf_mode_q != rem_mode_q) ? SrcMode : SrcRelay;
      e_mb_q       <= rem_mode_q;
      e_rb_q       <= rem_relays_q;
      e_mode_q     <= buf_mode_q;
      e_relays_q   <= buf_relays_q;
      e_temp_q     <= buf_temp_q;
      e_soil_q     <= buf_soil_q;
      e_light_q    <= buf_light_q;
      e_ph_q       <= buf_ph_q;
      e_rain_q     <= buf_rain_q;
      e_now_q      <= buf_now_q;
    end
    if (e_valid_q && emit && out_free) begin
      alarm_source_o  <= src;
      alarm_kind_o    <= kind;
      reading_o       <= reading;
      mode_before_o   <= e_mb_q;
      mode_now_o      <= e_mode_q;
      relays_before_o <= e_rb_q;
      relays_now_o    <= e_relays_q;
      alarm_mask_o    <= e_mask_new_q;
      beep_o          <= beep;
      final_item_o    <= fin;
    end
  end

  a_final_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && final_item_o |-> alarm_source_o == SrcStatus)
    else $error("final item without status source");

  a_beep_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && beep_o |-> final_item_o && (|alarm_mask_o[3:0]))
    else $error("beep outside status item or without alarm");

  a_stamp_write_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && e_slot_q != SlotStatus |-> e_flags_q.raise[ch] || e_mask_old_q[ch])
    else $error("stamp written for idle channel");

endmodule
